// ----- rtl/tph_pkg.sv -----
// tph_pkg: shared types and constants for the tph sensor compensation block
// word structs for the request, response and trim coefficients, plus pipeline payloads
// no dependencies
package tph_pkg;

   typedef enum logic [2:0] {
      CSR_TEMP_TRIM       = 3'd0,
      CSR_PRESS_TRIM_LOW  = 3'd1,
      CSR_PRESS_TRIM_HIGH = 3'd2,
      CSR_PRESS_TRIM_LAST = 3'd3,
      CSR_HUM_TRIM        = 3'd4,
      CSR_HUM_PRESENT     = 3'd5,
      CSR_DIVISOR_FLOOR   = 3'd6
   } tph_csr_index_type;

   localparam int NMAG_W = 80;
   localparam int DMAG_W = 40;
   localparam int QUO_W  = 37;

   typedef struct packed {
      logic [19:0] raw_temperature;
      logic [19:0] raw_pressure;
      logic [15:0] raw_humidity;
   } tph_req_type;

   typedef struct packed {
      logic signed [15:0] temperature_centi;
      logic [25:0]        pressure_q8;
      logic [16:0]        humidity_q10;
      logic               result_valid;
   } tph_rsp_type;

   typedef struct packed {
      logic [15:0]        t1;
      logic signed [15:0] t2;
      logic signed [15:0] t3;
      logic [15:0]        p1;
      logic signed [15:0] p2;
      logic signed [15:0] p3;
      logic signed [15:0] p4;
      logic signed [15:0] p5;
      logic signed [15:0] p6;
      logic signed [15:0] p7;
      logic signed [15:0] p8;
      logic signed [15:0] p9;
      logic [7:0]         h1;
      logic signed [15:0] h2;
      logic [7:0]         h3;
      logic signed [11:0] h4;
      logic signed [11:0] h5;
      logic signed [7:0]  h6;
      logic               hum_on;
      logic [15:0]        floor;
   } tph_trim_type;

   typedef struct packed {
      logic               dok;
      logic signed [15:0] temp;
      logic [16:0]        hum;
   } tph_side_type;

   typedef struct packed {
      logic [NMAG_W-1:0] nmag;
      logic [DMAG_W-1:0] dmag;
      logic              neg;
      tph_side_type      side;
   } tph_div_in_type;

   typedef struct packed {
      logic [QUO_W-1:0] qmag;
      logic             ovf;
      logic             neg;
      tph_side_type     side;
   } tph_quot_type;

endpackage

// ----- rtl/tph_front.sv -----
// tph_front: temperature, humidity and pressure polynomial stages ahead of the divider
// ten register stages; uses tph_pkg
module tph_front import tph_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           in_valid,
   input  tph_req_type    in_word,
   input  tph_trim_type   trim,
   output logic           out_valid,
   output tph_div_in_type out_word
);

   logic [9:0]  vld_ff, vld_in;
   tph_req_type req_ff [0:5];
   logic signed [15:0] temp_ff [0:6];

   // stage 1
   logic signed [17:0] s1_diff;
   logic signed [16:0] s1_d;
   logic signed [33:0] s1_pa_in, s1_pa_ff, s1_dd_in, s1_dd_ff;
   // stage 2
   logic signed [22:0] s2_a_in, s2_a_ff;
   logic signed [37:0] s2_b_in, s2_b_ff;
   // stage 3
   logic signed [24:0] s3_sum;
   logic signed [25:0] s3_f5;
   logic signed [17:0] s3_t;
   logic signed [21:0] s3_fine_in, s3_fine_ff;
   logic signed [15:0] s3_temp_in;
   // stage 4
   logic signed [22:0] s4_pa, s4_v;
   logic signed [45:0] s4_aa_in, s4_aa_ff;
   logic signed [38:0] s4_ap5_in, s4_ap5_ff, s4_ap2_in, s4_ap2_ff;
   logic signed [30:0] s4_vh6_in, s4_vh6_ff;
   logic signed [31:0] s4_vh3_in, s4_vh3_ff;
   logic signed [34:0] s4_h5v_in, s4_h5v_ff;
   // stage 5
   logic signed [61:0] s5_aap6_in, s5_aap6_ff, s5_aap3_in, s5_aap3_ff;
   logic signed [38:0] s5_ap5_ff, s5_ap2_ff;
   logic signed [36:0] s5_x;
   logic signed [21:0] s5_f1_in, s5_f1_ff, s5_u;
   logic signed [20:0] s5_t;
   logic signed [42:0] s5_tu_in, s5_tu_ff;
   // stage 6
   logic signed [63:0] s6_b_in, s6_b_ff;
   logic signed [55:0] s6_aden_in, s6_aden_ff;
   logic signed [33:0] s6_f2;
   logic signed [49:0] s6_f2h2_in, s6_f2h2_ff;
   logic signed [21:0] s6_f1_ff;
   // stage 7
   logic signed [72:0] s7_prod_in, s7_prod_ff;
   logic signed [63:0] s7_num_in, s7_num_ff;
   logic [20:0]        s7_pdiff;
   logic signed [49:0] s7_tmp;
   logic signed [35:0] s7_f2s;
   logic signed [57:0] s7_hv_in, s7_hv_ff;
   // stage 8
   logic signed [39:0] s8_den;
   logic [DMAG_W-1:0]  s8_dabs_in, s8_dabs_ff;
   logic               s8_dok_in, s8_dok_ff, s8_dneg_ff;
   logic signed [NMAG_W-1:0] s8_numx_in, s8_numx_ff;
   logic signed [41:0] s8_hvc_in, s8_hvc_ff;
   logic signed [26:0] s8_s;
   logic signed [53:0] s8_ss_in, s8_ss_ff;
   // stage 9
   logic [NMAG_W-1:0]  s9_nmag_in, s9_nmag_ff;
   logic [DMAG_W-1:0]  s9_dmag_ff;
   logic               s9_neg_in, s9_neg_ff, s9_dok_ff;
   logic signed [55:0] s9_k_in, s9_k_ff;
   logic signed [41:0] s9_hvc_ff;
   // stage 10
   logic signed [52:0] s10_hv;
   logic [16:0]        s10_hum_in;
   tph_div_in_type     s10_in, s10_ff;

   assign vld_in = {vld_ff[8:0], in_valid};

   always_comb begin
      s1_diff  = $signed({1'b0, in_word.raw_temperature[19:3]}) - $signed({1'b0, trim.t1, 1'b0});
      s1_d     = $signed({1'b0, in_word.raw_temperature[19:4]}) - $signed({1'b0, trim.t1});
      s1_pa_in = s1_diff * trim.t2;
      s1_dd_in = s1_d * s1_d;

      s2_a_in = $signed(s1_pa_ff[33:11]);
      s2_b_in = $signed(s1_dd_ff[33:12]) * trim.t3;

      s3_sum = 25'(s2_a_ff) + 25'($signed(s2_b_ff[37:14]));
      if (s3_sum > 25'sd2097151) begin
         s3_fine_in = 22'sd2097151;
      end else if (s3_sum < -25'sd2097152) begin
         s3_fine_in = -22'sd2097152;
      end else begin
         s3_fine_in = s3_sum[21:0];
      end
      s3_f5 = 26'(s3_fine_in) * 26'sd5 + 26'sd128;
      s3_t  = $signed(s3_f5[25:8]);
      if (s3_t > 18'sd32767) begin
         s3_temp_in = 16'sd32767;
      end else if (s3_t < -18'sd32768) begin
         s3_temp_in = -16'sd32768;
      end else begin
         s3_temp_in = s3_t[15:0];
      end

      s4_pa     = 23'(s3_fine_ff) - 23'sd128000;
      s4_v      = 23'(s3_fine_ff) - 23'sd76800;
      s4_aa_in  = s4_pa * s4_pa;
      s4_ap5_in = s4_pa * trim.p5;
      s4_ap2_in = s4_pa * trim.p2;
      s4_vh6_in = s4_v * trim.h6;
      s4_vh3_in = s4_v * $signed({1'b0, trim.h3});
      s4_h5v_in = s4_v * trim.h5;

      s5_aap6_in = s4_aa_ff * trim.p6;
      s5_aap3_in = s4_aa_ff * trim.p3;
      s5_x       = $signed({7'b0, req_ff[3].raw_humidity, 14'b0});
      s5_x       = s5_x - (37'(trim.h4) <<< 20) - 37'(s4_h5v_ff) + 37'sd16384;
      s5_f1_in   = $signed(s5_x[36:15]);
      s5_t       = $signed(s4_vh6_ff[30:10]);
      s5_u       = 22'($signed(s4_vh3_ff[31:11])) + 22'sd32768;
      s5_tu_in   = s5_t * s5_u;

      s6_b_in    = 64'(s5_aap6_ff) + (64'(s5_ap5_ff) <<< 17) + (64'(trim.p4) <<< 35);
      s6_aden_in = 56'(s5_aap3_ff >>> 8) + (56'(s5_ap2_ff) <<< 12) + (56'sd1 <<< 47);
      s6_f2      = 34'($signed(s5_tu_ff[42:10])) + 34'sd2097152;
      s6_f2h2_in = s6_f2 * trim.h2;

      s7_prod_in = s6_aden_ff * $signed({1'b0, trim.p1});
      s7_pdiff   = 21'd1048576 - {1'b0, req_ff[5].raw_pressure};
      s7_num_in  = $signed({12'b0, s7_pdiff, 31'b0}) - s6_b_ff;
      s7_tmp     = s6_f2h2_ff + 50'sd8192;
      s7_f2s     = $signed(s7_tmp[49:14]);
      s7_hv_in   = s6_f1_ff * s7_f2s;

      s8_den     = $signed(s7_prod_ff[72:33]);
      s8_dabs_in = s8_den[39] ? DMAG_W'(-s8_den) : DMAG_W'(s8_den);
      s8_dok_in  = (s8_den != 40'sd0) && ({s8_dabs_in, 2'b00} >= {26'b0, trim.floor});
      s8_numx_in = NMAG_W'(s7_num_ff) * 80'sd3125;
      if (s7_hv_ff > 58'sd1099511627776) begin
         s8_hvc_in = 42'sd1099511627776;
      end else if (s7_hv_ff < -58'sd1099511627776) begin
         s8_hvc_in = -42'sd1099511627776;
      end else begin
         s8_hvc_in = s7_hv_ff[41:0];
      end
      s8_s     = $signed(s8_hvc_in[41:15]);
      s8_ss_in = s8_s * s8_s;

      s9_nmag_in = s8_numx_ff[NMAG_W-1] ? NMAG_W'(-s8_numx_ff) : NMAG_W'(s8_numx_ff);
      s9_neg_in  = s8_numx_ff[NMAG_W-1] ^ s8_dneg_ff;
      s9_k_in    = $signed(s8_ss_ff[53:7]) * $signed({1'b0, trim.h1});

      s10_hv = 53'(s9_hvc_ff) - 53'($signed(s9_k_ff[55:4]));
      if (!trim.hum_on || s10_hv < 53'sd0) begin
         s10_hum_in = 17'd0;
      end else if (s10_hv > 53'sd419430400) begin
         s10_hum_in = 17'd102400;
      end else begin
         s10_hum_in = s10_hv[28:12];
      end

      s10_in.nmag      = s9_nmag_ff;
      s10_in.dmag      = s9_dmag_ff;
      s10_in.neg       = s9_neg_ff;
      s10_in.side.dok  = s9_dok_ff;
      s10_in.side.temp = temp_ff[6];
      s10_in.side.hum  = s10_hum_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff[0] <= in_word;
      for (int i = 1; i < 6; i++) begin
         req_ff[i] <= req_ff[i-1];
      end
      temp_ff[0] <= s3_temp_in;
      for (int i = 1; i < 7; i++) begin
         temp_ff[i] <= temp_ff[i-1];
      end
      s1_pa_ff   <= s1_pa_in;
      s1_dd_ff   <= s1_dd_in;
      s2_a_ff    <= s2_a_in;
      s2_b_ff    <= s2_b_in;
      s3_fine_ff <= s3_fine_in;
      s4_aa_ff   <= s4_aa_in;
      s4_ap5_ff  <= s4_ap5_in;
      s4_ap2_ff  <= s4_ap2_in;
      s4_vh6_ff  <= s4_vh6_in;
      s4_vh3_ff  <= s4_vh3_in;
      s4_h5v_ff  <= s4_h5v_in;
      s5_aap6_ff <= s5_aap6_in;
      s5_aap3_ff <= s5_aap3_in;
      s5_ap5_ff  <= s4_ap5_ff;
      s5_ap2_ff  <= s4_ap2_ff;
      s5_f1_ff   <= s5_f1_in;
      s5_tu_ff   <= s5_tu_in;
      s6_b_ff    <= s6_b_in;
      s6_aden_ff <= s6_aden_in;
      s6_f2h2_ff <= s6_f2h2_in;
      s6_f1_ff   <= s5_f1_ff;
      s7_prod_ff <= s7_prod_in;
      s7_num_ff  <= s7_num_in;
      s7_hv_ff   <= s7_hv_in;
      s8_dabs_ff <= s8_dabs_in;
      s8_dok_ff  <= s8_dok_in;
      s8_dneg_ff <= s8_den[39];
      s8_numx_ff <= s8_numx_in;
      s8_hvc_ff  <= s8_hvc_in;
      s8_ss_ff   <= s8_ss_in;
      s9_nmag_ff <= s9_nmag_in;
      s9_dmag_ff <= s8_dabs_ff;
      s9_neg_ff  <= s9_neg_in;
      s9_dok_ff  <= s8_dok_ff;
      s9_k_ff    <= s9_k_in;
      s9_hvc_ff  <= s8_hvc_ff;
      s10_ff     <= s10_in;
   end

   assign out_valid = vld_ff[9];
   assign out_word  = s10_ff;

endmodule

// ----- rtl/tph_div.sv -----
// tph_div: pipelined restoring divider for the pressure quotient, one bit per stage
// overflow check stage then one stage per quotient bit; uses tph_pkg
module tph_div import tph_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           in_valid,
   input  tph_div_in_type in_word,
   output logic           out_valid,
   output tph_quot_type   out_word
);

   localparam int STAGES = QUO_W + 1;

   logic [STAGES-1:0] vld_ff, vld_in;
   logic [NMAG_W-1:0] rem_ff [0:STAGES-1];
   logic [NMAG_W-1:0] rem_in [0:STAGES-1];
   logic [QUO_W-1:0]  quo_ff [0:STAGES-1];
   logic [QUO_W-1:0]  quo_in [0:STAGES-1];
   tph_quot_type      ctl_ff [0:STAGES-1];
   tph_quot_type      ctl_in [0:STAGES-1];
   logic [DMAG_W-1:0] dmag_ff [0:STAGES-1];

   assign vld_in = {vld_ff[STAGES-2:0], in_valid};

   always_comb begin
      rem_in[0]       = in_word.nmag;
      quo_in[0]       = '0;
      ctl_in[0].qmag  = '0;
      ctl_in[0].ovf   = in_word.nmag >= {{(NMAG_W-DMAG_W-QUO_W){1'b0}}, in_word.dmag,
                                         {QUO_W{1'b0}}};
      ctl_in[0].neg   = in_word.neg;
      ctl_in[0].side  = in_word.side;
   end

   for (genvar j = 1; j < STAGES; j++) begin : g_bit
      logic [NMAG_W-1:0] dsh;
      logic              ge;
      always_comb begin
         dsh       = {{(NMAG_W-DMAG_W){1'b0}}, dmag_ff[j-1]} << (QUO_W - j);
         ge        = rem_ff[j-1] >= dsh;
         rem_in[j] = ge ? rem_ff[j-1] - dsh : rem_ff[j-1];
         quo_in[j] = quo_ff[j-1];
         quo_in[j][QUO_W-j] = ge;
         ctl_in[j] = ctl_ff[j-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      dmag_ff[0] <= in_word.dmag;
      for (int i = 0; i < STAGES; i++) begin
         rem_ff[i] <= rem_in[i];
         quo_ff[i] <= quo_in[i];
         ctl_ff[i] <= ctl_in[i];
      end
      for (int i = 1; i < STAGES; i++) begin
         dmag_ff[i] <= dmag_ff[i-1];
      end
   end

   always_comb begin
      out_word      = ctl_ff[STAGES-1];
      out_word.qmag = quo_ff[STAGES-1];
   end
   assign out_valid = vld_ff[STAGES-1];

endmodule

// ----- rtl/tph_post.sv -----
// tph_post: pressure saturation and second-order correction, result word assembly
// three register stages after the divider; uses tph_pkg
module tph_post import tph_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         in_valid,
   input  tph_quot_type in_word,
   input  tph_trim_type trim,
   output logic         out_valid,
   output tph_rsp_type  out_word
);

   localparam logic [QUO_W-1:0] PLIM = QUO_W'(1) << 36;

   logic [2:0] vld_ff, vld_in;

   logic [QUO_W-1:0]   p1_mag;
   logic signed [37:0] p1_p_in, p1_p_ff, p2_p_ff;
   logic signed [24:0] p1_ps;
   logic signed [49:0] p1_pp_in, p1_pp_ff;
   logic signed [53:0] p1_p8p_in, p1_p8p_ff;
   tph_side_type       p1_side_ff, p2_side_ff;
   logic signed [65:0] p2_prod;
   logic signed [40:0] p2_a_in, p2_a_ff;
   logic signed [34:0] p2_b_in, p2_b_ff;
   logic signed [41:0] p3_sum;
   logic signed [33:0] p3_tot;
   tph_rsp_type        p3_in, p3_ff;

   assign vld_in = {vld_ff[1:0], in_valid};

   always_comb begin
      p1_mag    = (in_word.ovf || in_word.qmag > PLIM) ? PLIM : in_word.qmag;
      p1_p_in   = in_word.neg ? -$signed({1'b0, p1_mag}) : $signed({1'b0, p1_mag});
      p1_ps     = $signed(p1_p_in[37:13]);
      p1_pp_in  = p1_ps * p1_ps;
      p1_p8p_in = p1_p_in * trim.p8;

      p2_prod = p1_pp_ff * trim.p9;
      p2_a_in = $signed(p2_prod[65:25]);
      p2_b_in = $signed(p1_p8p_ff[53:19]);

      p3_sum = 42'(p2_p_ff) + 42'(p2_a_ff) + 42'(p2_b_ff);
      p3_tot = 34'($signed(p3_sum[41:8])) + (34'(trim.p7) <<< 4);

      p3_in.temperature_centi = p2_side_ff.temp;
      p3_in.result_valid      = p2_side_ff.dok;
      p3_in.humidity_q10      = p2_side_ff.dok ? p2_side_ff.hum : 17'd0;
      if (!p2_side_ff.dok || p3_tot < 34'sd0) begin
         p3_in.pressure_q8 = 26'd0;
      end else if (p3_tot > 34'sd67108863) begin
         p3_in.pressure_q8 = 26'h3ffffff;
      end else begin
         p3_in.pressure_q8 = p3_tot[25:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      p1_p_ff    <= p1_p_in;
      p1_pp_ff   <= p1_pp_in;
      p1_p8p_ff  <= p1_p8p_in;
      p1_side_ff <= in_word.side;
      p2_p_ff    <= p1_p_ff;
      p2_a_ff    <= p2_a_in;
      p2_b_ff    <= p2_b_in;
      p2_side_ff <= p1_side_ff;
      p3_ff      <= p3_in;
   end

   assign out_valid = vld_ff[2];
   assign out_word  = p3_ff;

endmodule

// ----- rtl/tph_sensor_compensation.sv -----
// tph_sensor_compensation: top level, trim registers and the compensation pipeline
// instantiates tph_front, tph_div and tph_post; uses tph_pkg
//
// usage
//   a raw sample word is taken on req_data at a clock edge where start is high and busy
//   is low; busy is high during reset and up to the first edge after it, and after that
//   one word per cycle goes in; each word gives one result word on rsp_data, marked by
//   rsp_strobe for one cycle, after 51 register stages, the first loaded at the edge
//   that took it: ten polynomial stages, one overflow check plus 37 divider stages (one
//   quotient bit each), three pressure correction stages
//   throughput is one word per cycle; the divider is fully pipelined
//   results come out in input order and the receiver cannot stall them
//   trim registers are written on the csr channel (csr_valid and csr_ready, csr_index,
//   csr_data); the user must write them only while no word is in flight, the block does
//   not enforce it; csr_ready is always high, an index beyond the register list is dropped
//   reset clears the pipeline valid bits and loads the trim reset values
//   (all zero, humidity present, divisor floor one)
module tph_sensor_compensation import tph_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  tph_req_type req_data,
   output logic        rsp_strobe,
   output tph_rsp_type rsp_data,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [63:0] csr_data
);

   logic [47:0] temp_trim_ff, temp_trim_in;
   logic [63:0] press_low_ff, press_low_in;
   logic [63:0] press_high_ff, press_high_in;
   logic [15:0] press_last_ff, press_last_in;
   logic [63:0] hum_trim_ff, hum_trim_in;
   logic        hum_on_ff, hum_on_in;
   logic [15:0] floor_ff, floor_in;
   logic        busy_ff;

   tph_trim_type   trim;
   logic           accept;
   logic           front_valid, div_valid;
   tph_div_in_type front_word;
   tph_quot_type   div_word;

   assign accept    = start && !busy_ff;
   assign busy      = busy_ff;
   assign csr_ready = 1'b1;

   always_comb begin
      temp_trim_in  = temp_trim_ff;
      press_low_in  = press_low_ff;
      press_high_in = press_high_ff;
      press_last_in = press_last_ff;
      hum_trim_in   = hum_trim_ff;
      hum_on_in     = hum_on_ff;
      floor_in      = floor_ff;
      if (csr_valid) begin
         unique case (tph_csr_index_type'(csr_index))
            CSR_TEMP_TRIM:       temp_trim_in  = csr_data[47:0];
            CSR_PRESS_TRIM_LOW:  press_low_in  = csr_data;
            CSR_PRESS_TRIM_HIGH: press_high_in = csr_data;
            CSR_PRESS_TRIM_LAST: press_last_in = csr_data[15:0];
            CSR_HUM_TRIM:        hum_trim_in   = csr_data;
            CSR_HUM_PRESENT:     hum_on_in     = csr_data[0];
            CSR_DIVISOR_FLOOR:   floor_in      = csr_data[15:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         temp_trim_ff  <= '0;
         press_low_ff  <= '0;
         press_high_ff <= '0;
         press_last_ff <= '0;
         hum_trim_ff   <= '0;
         hum_on_ff     <= 1'b1;
         floor_ff      <= 16'd1;
         busy_ff       <= 1'b1;
      end else begin
         temp_trim_ff  <= temp_trim_in;
         press_low_ff  <= press_low_in;
         press_high_ff <= press_high_in;
         press_last_ff <= press_last_in;
         hum_trim_ff   <= hum_trim_in;
         hum_on_ff     <= hum_on_in;
         floor_ff      <= floor_in;
         busy_ff       <= 1'b0;
      end
   end

   always_comb begin
      trim.t1     = temp_trim_ff[15:0];
      trim.t2     = $signed(temp_trim_ff[31:16]);
      trim.t3     = $signed(temp_trim_ff[47:32]);
      trim.p1     = press_low_ff[15:0];
      trim.p2     = $signed(press_low_ff[31:16]);
      trim.p3     = $signed(press_low_ff[47:32]);
      trim.p4     = $signed(press_low_ff[63:48]);
      trim.p5     = $signed(press_high_ff[15:0]);
      trim.p6     = $signed(press_high_ff[31:16]);
      trim.p7     = $signed(press_high_ff[47:32]);
      trim.p8     = $signed(press_high_ff[63:48]);
      trim.p9     = $signed(press_last_ff);
      trim.h1     = hum_trim_ff[7:0];
      trim.h2     = $signed(hum_trim_ff[23:8]);
      trim.h3     = hum_trim_ff[31:24];
      trim.h4     = $signed(hum_trim_ff[43:32]);
      trim.h5     = $signed(hum_trim_ff[55:44]);
      trim.h6     = $signed(hum_trim_ff[63:56]);
      trim.hum_on = hum_on_ff;
      trim.floor  = floor_ff;
   end

   tph_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (accept),
      .in_word   (req_data),
      .trim      (trim),
      .out_valid (front_valid),
      .out_word  (front_word)
   );

   tph_div u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (front_valid),
      .in_word   (front_word),
      .out_valid (div_valid),
      .out_word  (div_word)
   );

   tph_post u_post (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (div_valid),
      .in_word   (div_word),
      .trim      (trim),
      .out_valid (rsp_strobe),
      .out_word  (rsp_data)
   );

endmodule
